@@ src/mcr_pkg.sv @@
// mcr_pkg: shared types and constants of the midpoint circle rasterizer
// no dependencies; used by mcr_step and midpoint_circle_rasterizer_top

package mcr_pkg;

  localparam int RING_W  = 4;   // ring radius and octant offset width
  localparam int COORD_W = 15;  // unsigned centre coordinate width
  localparam int PSIZE_W = 5;   // point_size register width
  localparam int POS_W   = 6;   // signed walk position width
  localparam int STEP_W  = 6;   // dx, dy increment width
  localparam int ERR_W   = 8;   // signed decision term width

  typedef struct packed {
    logic signed [POS_W-1:0] a;
    logic signed [POS_W-1:0] b;
    logic [STEP_W-1:0]       dx;
    logic [STEP_W-1:0]       dy;
    logic signed [ERR_W-1:0] err;
  } step_t;

  // walk state at the start of a ring of radius r: a = r-1, b = 0, err = 1 - 2r
  function automatic step_t ring_init(input logic [RING_W-1:0] r);
    step_t s;
    s.a   = $signed({{(POS_W-RING_W){1'b0}}, r}) - POS_W'(1);
    s.b   = '0;
    s.dx  = STEP_W'(1);
    s.dy  = STEP_W'(1);
    s.err = ERR_W'(1) - $signed({{(ERR_W-RING_W-1){1'b0}}, r, 1'b0});
    return s;
  endfunction

endpackage

@@ src/midpoint_circle_rasterizer_top.sv @@
// midpoint circle rasterizer: one result beat per cycle while busy, receiver cannot stall
// first result is registered once busy is set; then one beat per cycle, no gaps,
// an outline ring of radius r gives about 0.7*r beats, a filled disc the sum over rings 1..r;
// the single step unit (one midpoint iteration per cycle) sets that rate
// busy drops as the last beat is registered, so a new start is taken in the cycle it shows
// synchronous active-high reset clears control state; point_size resets to 6

module midpoint_circle_rasterizer_top #(
  parameter int MAX_RADIUS = 11
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           mode,
  input  logic signed [15:0]             center_x,
  input  logic signed [15:0]             center_y,
  input  logic signed [15:0]             radius,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mcr_pkg::PSIZE_W-1:0]    cfg_data,
  output logic                           result_valid,
  output logic [mcr_pkg::COORD_W-1:0]    out_center_x,
  output logic [mcr_pkg::COORD_W-1:0]    out_center_y,
  output logic [mcr_pkg::RING_W-1:0]     offset_a,
  output logic [mcr_pkg::RING_W-1:0]     offset_b,
  output logic [mcr_pkg::RING_W-1:0]     ring_radius,
  output logic                           last
);

  localparam logic [mcr_pkg::RING_W-1:0] RMAX = mcr_pkg::RING_W'(MAX_RADIUS);

  logic [mcr_pkg::PSIZE_W-1:0]  point_size;
  logic [mcr_pkg::COORD_W-1:0]  hold_x;
  logic [mcr_pkg::COORD_W-1:0]  hold_y;
  logic [mcr_pkg::RING_W-1:0]   ring;
  logic [mcr_pkg::RING_W-1:0]   target;
  mcr_pkg::step_t               walk;
  mcr_pkg::step_t               walk_next;
  logic                         ring_done;
  logic                         final_ring;

  logic                         take;
  logic                         req_ok;
  logic [14:0]                  rad_raw;
  logic [mcr_pkg::RING_W-1:0]   rad_sat;
  logic [mcr_pkg::RING_W-1:0]   first_ring;
  logic [mcr_pkg::RING_W-1:0]   ring_inc;

  assign cfg_ready = 1'b1;
  assign take      = start && !busy;

  // request decode: zero radius takes half the point size, large radii clamp
  always_comb begin
    if (radius == 16'sd0)
      rad_raw = {{(15-mcr_pkg::PSIZE_W+1){1'b0}}, point_size[mcr_pkg::PSIZE_W-1:1]};
    else
      rad_raw = radius[14:0];
    rad_sat    = (rad_raw > 15'(MAX_RADIUS)) ? RMAX : rad_raw[mcr_pkg::RING_W-1:0];
    req_ok     = !center_x[15] && !center_y[15] && !radius[15] && (rad_sat != '0);
    first_ring = mode ? mcr_pkg::RING_W'(1) : rad_sat;
  end

  mcr_step u_step (
    .cur       (walk),
    .ring      (ring),
    .nxt       (walk_next),
    .ring_done (ring_done)
  );

  assign final_ring = (ring == target);
  assign ring_inc   = ring + mcr_pkg::RING_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      point_size   <= mcr_pkg::PSIZE_W'(6);
      busy         <= 1'b0;
      result_valid <= 1'b0;
      last         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready)
        point_size <= cfg_data;
      result_valid <= busy;
      last         <= busy && ring_done && final_ring;
      if (take && req_ok)
        busy <= 1'b1;
      else if (busy && ring_done && final_ring)
        busy <= 1'b0;
    end
  end

  // walk registers and result payload
  always_ff @(posedge clk) begin
    if (take) begin
      hold_x <= center_x[14:0];
      hold_y <= center_y[14:0];
      target <= rad_sat;
      ring   <= first_ring;
      walk   <= mcr_pkg::ring_init(first_ring);
    end else if (busy) begin
      if (ring_done && !final_ring) begin
        ring <= ring_inc;
        walk <= mcr_pkg::ring_init(ring_inc);
      end else begin
        walk <= walk_next;
      end
    end
    if (busy) begin
      out_center_x <= hold_x;
      out_center_y <= hold_y;
      offset_a     <= walk.a[mcr_pkg::RING_W-1:0];
      offset_b     <= walk.b[mcr_pkg::RING_W-1:0];
      ring_radius  <= ring;
    end
  end

endmodule

@@ src/mcr_step.sv @@
// mcr_step: one midpoint circle iteration, the shared update unit
// depends on mcr_pkg (step_t and widths)

module mcr_step (
  input  mcr_pkg::step_t              cur,
  input  logic [mcr_pkg::RING_W-1:0]  ring,
  output mcr_pkg::step_t              nxt,
  output logic                        ring_done
);

  logic signed [mcr_pkg::ERR_W-1:0]  err_mid;
  logic [mcr_pkg::STEP_W-1:0]        dx_new;
  logic signed [mcr_pkg::ERR_W-1:0]  two_r;

  assign two_r = $signed({{(mcr_pkg::ERR_W-mcr_pkg::RING_W-1){1'b0}}, ring, 1'b0});

  always_comb begin
    nxt     = cur;
    err_mid = cur.err;
    dx_new  = cur.dx + mcr_pkg::STEP_W'(2);
    // vertical step while the decision term is not positive
    if (cur.err <= 0) begin
      nxt.b   = cur.b + mcr_pkg::POS_W'(1);
      err_mid = cur.err + $signed({{(mcr_pkg::ERR_W-mcr_pkg::STEP_W){1'b0}}, cur.dy});
      nxt.dy  = cur.dy + mcr_pkg::STEP_W'(2);
    end
    nxt.err = err_mid;
    // then a diagonal correction if it went positive
    if (err_mid > 0) begin
      nxt.a   = cur.a - mcr_pkg::POS_W'(1);
      nxt.dx  = dx_new;
      nxt.err = err_mid + $signed({{(mcr_pkg::ERR_W-mcr_pkg::STEP_W){1'b0}}, dx_new})
                - two_r;
    end
  end

  assign ring_done = (nxt.a < nxt.b);

endmodule

@@ src/midpoint_circle_rasterizer_chk.sv @@
// port-level checker for the midpoint circle rasterizer, bound to the top level
// depends on midpoint_circle_rasterizer_top ports only

module midpoint_circle_rasterizer_chk (
  input logic       clk,
  input logic       rst,
  input logic       busy,
  input logic       result_valid,
  input logic [3:0] offset_a,
  input logic [3:0] offset_b,
  input logic [3:0] ring_radius,
  input logic       last
);

  // a result beat only ever follows a busy cycle
  a_beat_after_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result beat without preceding busy cycle");

  // leaving busy always coincides with the final beat
  a_fall_gives_last: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> (result_valid && last))
    else $error("busy fell without a last beat");

  // beats of one request come back to back
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last) |=> result_valid)
    else $error("gap inside a request");

  // octant offsets stay in the first octant of a non-empty ring
  a_octant: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (offset_a >= offset_b && ring_radius != 4'd0 && offset_a < ring_radius))
    else $error("offsets out of octant");

  a_last_strobed: assert property (@(posedge clk) disable iff (rst)
    last |-> result_valid)
    else $error("last without result beat");

endmodule

bind midpoint_circle_rasterizer_top midpoint_circle_rasterizer_chk u_chk (
  .clk          (clk),
  .rst          (rst),
  .busy         (busy),
  .result_valid (result_valid),
  .offset_a     (offset_a),
  .offset_b     (offset_b),
  .ring_radius  (ring_radius),
  .last         (last)
);

@@ dv/tb_midpoint_circle_rasterizer_top.sv @@
// testbench for midpoint_circle_rasterizer_top: directed table then random circle requests
// beats are checked against an in-bench ring walker; depends on src/mcr_pkg.sv and the rtl top
`timescale 1ns / 1ps

module tb_midpoint_circle_rasterizer_top;

  localparam int MAX_RADIUS    = 11;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 20;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_PHASES = 4;
  localparam int PHASE_ITEMS   = 25;

  typedef enum logic [1:0] {
    ROW_PREDICT,  // expectation from the ring walker
    ROW_NONE,     // request must produce no beat
    ROW_UNIT,     // radius one: single beat at offsets (0,0)
    ROW_CFG       // point_size write, value in the radius column
  } row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic               md;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] rad;
  } stim_row_t;

  typedef struct packed {
    logic [mcr_pkg::COORD_W-1:0] cx;
    logic [mcr_pkg::COORD_W-1:0] cy;
    logic [mcr_pkg::RING_W-1:0]  oa;
    logic [mcr_pkg::RING_W-1:0]  ob;
    logic [mcr_pkg::RING_W-1:0]  ring_r;
    logic                        fin;
  } circle_beat_t;

  localparam int DIRECTED_LEN = 24;
  localparam stim_row_t DIRECTED_ROWS [0:DIRECTED_LEN-1] = '{
    '{ROW_PREDICT, 1'b0, 16'sd100,    16'sd200,    16'sd0},      // default radius after reset
    '{ROW_UNIT,    1'b0, 16'sd0,      16'sd0,      16'sd1},
    '{ROW_UNIT,    1'b1, 16'sd32767,  16'sd32767,  16'sd1},
    '{ROW_PREDICT, 1'b0, 16'sd21845,  16'sd10922,  16'sd11},
    '{ROW_PREDICT, 1'b1, 16'sd1,      16'sd32767,  16'sd11},
    '{ROW_PREDICT, 1'b0, 16'sd32767,  16'sd0,      16'sd32767},  // clamps to max radius
    '{ROW_PREDICT, 1'b1, 16'sd5,      16'sd5,      16'sd12},
    '{ROW_NONE,    1'b0, -16'sd1,     16'sd5,      16'sd3},
    '{ROW_NONE,    1'b1, 16'sd5,      -16'sd32768, 16'sd3},
    '{ROW_NONE,    1'b0, 16'sd5,      16'sd5,      -16'sd1},
    '{ROW_NONE,    1'b1, 16'sd32767,  16'sd32767,  -16'sd32768},
    '{ROW_NONE,    1'b1, -16'sd1,     -16'sd1,     -16'sd1},
    '{ROW_PREDICT, 1'b0, 16'sd16384,  16'sd1,      16'sd2},
    '{ROW_PREDICT, 1'b1, 16'sd2,      16'sd16384,  16'sd5},
    '{ROW_CFG,     1'b0, 16'sd0,      16'sd0,      16'sd0},
    '{ROW_NONE,    1'b0, 16'sd10,     16'sd10,     16'sd0},      // zero default radius
    '{ROW_CFG,     1'b0, 16'sd0,      16'sd0,      16'sd1},
    '{ROW_NONE,    1'b1, 16'sd10,     16'sd10,     16'sd0},
    '{ROW_CFG,     1'b0, 16'sd0,      16'sd0,      16'sd23},
    '{ROW_PREDICT, 1'b1, 16'sd300,    16'sd400,    16'sd0},
    '{ROW_CFG,     1'b0, 16'sd0,      16'sd0,      16'sd31},
    '{ROW_PREDICT, 1'b0, 16'sd300,    16'sd400,    16'sd0},      // default above max clamps
    '{ROW_CFG,     1'b0, 16'sd0,      16'sd0,      16'sd2},
    '{ROW_UNIT,    1'b1, 16'sd7,      16'sd9,      16'sd0}
  };

  logic                           clk;
  logic                           rst;
  logic                           start;
  logic                           busy;
  logic                           mode;
  logic signed [15:0]             center_x;
  logic signed [15:0]             center_y;
  logic signed [15:0]             radius;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [mcr_pkg::PSIZE_W-1:0]    cfg_data;
  logic                           result_valid;
  logic [mcr_pkg::COORD_W-1:0]    out_center_x;
  logic [mcr_pkg::COORD_W-1:0]    out_center_y;
  logic [mcr_pkg::RING_W-1:0]     offset_a;
  logic [mcr_pkg::RING_W-1:0]     offset_b;
  logic [mcr_pkg::RING_W-1:0]     ring_radius;
  logic                           last;

  row_kind_t                      cur_kind;
  logic [mcr_pkg::PSIZE_W-1:0]    psize_model;
  circle_beat_t                   expected_beats [$];
  int                             requests_taken;
  int                             cfg_writes;
  int                             mismatch_count;
  int                             quiet_cycles;

  midpoint_circle_rasterizer_top #(
    .MAX_RADIUS(MAX_RADIUS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .center_x    (center_x),
    .center_y    (center_y),
    .radius      (radius),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .result_valid(result_valid),
    .out_center_x(out_center_x),
    .out_center_y(out_center_y),
    .offset_a    (offset_a),
    .offset_b    (offset_b),
    .ring_radius (ring_radius),
    .last        (last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // walks every ring of the request and queues one beat per octant step
  function automatic void predict_circle(input logic md, input logic signed [15:0] x,
                                         input logic signed [15:0] y,
                                         input logic signed [15:0] rq);
    int r;
    int base;
    int a;
    int b;
    int dx;
    int dy;
    int err;
    circle_beat_t beat;
    if (x < 0 || y < 0 || rq < 0) return;
    r = (rq == 0) ? int'(psize_model >> 1) : int'(rq);
    if (r > MAX_RADIUS) r = MAX_RADIUS;
    if (r == 0) return;
    base = expected_beats.size();
    for (int rr = (md ? 1 : r); rr <= r; rr++) begin
      a   = rr - 1;
      b   = 0;
      dx  = 1;
      dy  = 1;
      err = 1 - 2 * rr;
      while (a >= b && expected_beats.size() - base < 64) begin
        beat.cx     = x[mcr_pkg::COORD_W-1:0];
        beat.cy     = y[mcr_pkg::COORD_W-1:0];
        beat.oa     = mcr_pkg::RING_W'(a);
        beat.ob     = mcr_pkg::RING_W'(b);
        beat.ring_r = mcr_pkg::RING_W'(rr);
        beat.fin    = 1'b0;
        expected_beats.push_back(beat);
        if (err <= 0) begin
          b++;
          err += dy;
          dy  += 2;
        end
        if (err > 0) begin
          a--;
          dx  += 2;
          err += dx - 2 * rr;
        end
      end
    end
    if (expected_beats.size() > base) expected_beats[expected_beats.size() - 1].fin = 1'b1;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    circle_beat_t want;
    circle_beat_t unit;
    if (!rst) begin
      if (result_valid) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected beat: ring_radius %0d offset_a %0d offset_b %0d",
                 ring_radius, offset_a, offset_b);
          mismatch_count++;
        end else begin
          want = expected_beats.pop_front();
          check_field("out_center_x", want.cx, out_center_x);
          check_field("out_center_y", want.cy, out_center_y);
          check_field("offset_a", want.oa, offset_a);
          check_field("offset_b", want.ob, offset_b);
          check_field("ring_radius", want.ring_r, ring_radius);
          check_field("last", want.fin, last);
        end
      end
      if (start && !busy) begin
        case (cur_kind)
          ROW_PREDICT: predict_circle(mode, center_x, center_y, radius);
          ROW_UNIT: begin
            unit.cx     = center_x[mcr_pkg::COORD_W-1:0];
            unit.cy     = center_y[mcr_pkg::COORD_W-1:0];
            unit.oa     = '0;
            unit.ob     = '0;
            unit.ring_r = mcr_pkg::RING_W'(1);
            unit.fin    = 1'b1;
            expected_beats.push_back(unit);
          end
          default: ;
        endcase
        requests_taken++;
      end
      if (cfg_valid && cfg_ready) begin
        psize_model = cfg_data;
        cfg_writes++;
      end
    end
  end

  // watchdog on cycles with no beat of any kind
  always @(posedge clk) begin
    if (rst || result_valid || (start && !busy) || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // called and returns just after a falling edge
  task automatic send_request(input row_kind_t kind, input logic md,
                              input logic signed [15:0] x, input logic signed [15:0] y,
                              input logic signed [15:0] r, input int gap);
    int seen;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    seen = requests_taken;
    cur_kind <= kind;
    mode     <= md;
    center_x <= x;
    center_y <= y;
    radius   <= r;
    start    <= 1'b1;
    while (requests_taken == seen) @(negedge clk);
  endtask

  // register writes only once the block has drained
  task automatic write_point_size(input logic [mcr_pkg::PSIZE_W-1:0] value);
    int seen;
    start <= 1'b0;
    while (expected_beats.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    seen = cfg_writes;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    while (cfg_writes == seen) @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic               burst;
    logic               md;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] r;
    int                 sel;
    rst            = 1'b1;
    start          = 1'b0;
    mode           = 1'b0;
    center_x       = '0;
    center_y       = '0;
    radius         = '0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    cur_kind       = ROW_NONE;
    psize_model    = mcr_pkg::PSIZE_W'(6);
    requests_taken = 0;
    cfg_writes     = 0;
    mismatch_count = 0;
    burst          = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_LEN; i++) begin
      if (DIRECTED_ROWS[i].kind == ROW_CFG)
        write_point_size(DIRECTED_ROWS[i].rad[mcr_pkg::PSIZE_W-1:0]);
      else
        send_request(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].md, DIRECTED_ROWS[i].x,
                     DIRECTED_ROWS[i].y, DIRECTED_ROWS[i].rad, $urandom_range(0, 9));
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_point_size(mcr_pkg::PSIZE_W'($urandom_range(0, 31)));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // back-to-back stretches come and go
        if ($urandom_range(0, 7) == 0) burst = !burst;
        sel = $urandom_range(0, 9);
        md  = 1'($urandom);
        if (sel == 0) begin
          x = 16'($urandom);
          y = 16'($urandom);
          r = 16'($urandom);
        end else begin
          x = 16'($urandom_range(0, 32767));
          y = 16'($urandom_range(0, 32767));
          if (sel < 7)      r = 16'($urandom_range(0, MAX_RADIUS));
          else if (sel < 9) r = 16'($urandom_range(1, 4));
          else              r = 16'($urandom_range(MAX_RADIUS + 1, 32767));
        end
        send_request(ROW_PREDICT, md, x, y, r, burst ? 0 : $urandom_range(0, 9));
      end
    end

    start <= 1'b0;
    while (expected_beats.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
